@@ rtl/maze_carver_dfs_top_defines.svh @@
// Assertion macros used by the checker of the maze carver (mcd_checker.sv).
`ifndef MAZE_CARVER_DFS_TOP_DEFINES_SVH
`define MAZE_CARVER_DFS_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mcd_pkg.sv @@
package mcd_pkg;

   // Configuration register width and indexes
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMNS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS    = 1'b1;

   // Actions
   localparam logic [1:0] ACT_RESTART = 2'd0;
   localparam logic [1:0] ACT_STEP    = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_CARVED  = 3'd0;
   localparam logic [2:0] ST_BACK    = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_RESTART = 3'd3;
   localparam logic [2:0] ST_READ    = 3'd4;

   // Wall-open bits
   localparam logic [3:0] W_PY = 4'b0001;
   localparam logic [3:0] W_MY = 4'b0010;
   localparam logic [3:0] W_MX = 4'b0100;
   localparam logic [3:0] W_PX = 4'b1000;

   // Neighbour directions, in search order
   localparam logic [1:0] DIR_MX = 2'd0;
   localparam logic [1:0] DIR_MY = 2'd1;
   localparam logic [1:0] DIR_PY = 2'd2;
   localparam logic [1:0] DIR_PX = 2'd3;

   localparam int CARVED_W = 13;
   localparam logic [CARVED_W-1:0] CARVED_MAX = 13'h1FFF;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CLEAR = 8'b0000_0010,
      S_NB    = 8'b0000_0100,
      S_SELF  = 8'b0000_1000,
      S_PICK  = 8'b0001_0000,
      S_WRA   = 8'b0010_0000,
      S_POP   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   // Bit opened in the current cell when moving in a direction
   function automatic logic [3:0] wall_from(input logic [1:0] dir);
      logic [3:0] w;
      case (dir)
         DIR_MX:  w = W_MX;
         DIR_MY:  w = W_MY;
         DIR_PY:  w = W_PY;
         DIR_PX:  w = W_PX;
         default: w = 4'b0000;
      endcase
      return w;
   endfunction

   // Bit opened in the new cell when entered from a direction
   function automatic logic [3:0] wall_to(input logic [1:0] dir);
      logic [3:0] w;
      case (dir)
         DIR_MX:  w = W_PX;
         DIR_MY:  w = W_PY;
         DIR_PY:  w = W_MY;
         DIR_PX:  w = W_MX;
         default: w = 4'b0000;
      endcase
      return w;
   endfunction

   // v mod 3 for an 8-bit value: reciprocal multiply, exact over 0..255
   function automatic logic [1:0] mod3_u8(input logic [7:0] v);
      logic [16:0] prod;
      logic [7:0]  q;
      logic [9:0]  back;
      logic [9:0]  diff;
      prod = 17'(v) * 17'd171;
      q    = prod[16:9];
      back = 10'(q) * 10'd3;
      diff = 10'(v) - back;
      return diff[1:0];
   endfunction

endpackage

@@ rtl/maze_carver_dfs_top.sv @@
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ---------------------------------------------
// req       in         req_valid/req_ready  action, random_value, query_x, query_y
// rsp       out        rsp_valid/rsp_ready  status, from/to x/y, walls_open, more_to_do
// csr       in         csr_we (no wait)     csr_index, csr_wdata (columns, rows)
//
// Carving or backtracking step: S_NB, S_SELF, S_PICK, then S_WRA or S_POP, then S_DONE
// loads the result register, bounded by the two-port wall memory (four neighbour reads,
// own cell read, two write-backs). Read and finished-maze steps go straight to S_DONE.
// Restart sweeps all MAX_COLS*MAX_ROWS wall cells first, as does reset, with req_ready low.
// A result waiting on rsp_ready holds in its register; the next request is taken meanwhile.
module maze_carver_dfs_top
   import mcd_pkg::*;
#(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic [7:0]           req_random_value,
   input  logic [5:0]           req_query_x,
   input  logic [5:0]           req_query_y,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [5:0]           rsp_from_x,
   output logic [5:0]           rsp_from_y,
   output logic [5:0]           rsp_to_x,
   output logic [5:0]           rsp_to_y,
   output logic [3:0]           rsp_walls_open,
   output logic                 rsp_more_to_do
);

   localparam int CAP     = MAX_COLS * MAX_ROWS;
   localparam int AW      = $clog2(CAP);
   localparam int DW      = $clog2(CAP + 1);
   localparam int CW      = $clog2(MAX_COLS);
   localparam int RW      = $clog2(MAX_ROWS);
   localparam int CMAX    = (CW > RW) ? CW : RW;
   localparam int XW      = (CMAX + 1 > CFG_W) ? CMAX + 1 : CFG_W;
   localparam int COL_RST = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int ROW_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int SW      = CW + RW;

   // Control and geometry registers
   state_type              state_ff, state_in;
   logic [CFG_W-1:0]       columns_ff, columns_in;
   logic [CFG_W-1:0]       rows_ff, rows_in;
   logic [DW-1:0]          depth_ff, depth_in;
   logic [CARVED_W-1:0]    carved_ff, carved_in;
   logic [CW-1:0]          top_x_ff, top_x_in;
   logic [RW-1:0]          top_y_ff, top_y_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic                   clr_reply_ff, clr_reply_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Per-item work registers
   logic [2:0]             status_ff, status_in;
   logic [5:0]             from_x_ff, from_x_in;
   logic [5:0]             from_y_ff, from_y_in;
   logic [CW-1:0]          tgt_x_ff, tgt_x_in;
   logic [RW-1:0]          tgt_y_ff, tgt_y_in;
   logic [7:0]             rnd_ff, rnd_in;
   logic                   qok_ff, qok_in;
   logic [1:0]             dir_ff, dir_in;
   logic [3:0]             self_ff, self_in;
   logic [3:0]             nb_ff [4];
   logic [3:0]             nb_in [4];

   // Result register
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic [5:0]             rsp_from_x_ff, rsp_from_x_in;
   logic [5:0]             rsp_from_y_ff, rsp_from_y_in;
   logic [5:0]             rsp_to_x_ff, rsp_to_x_in;
   logic [5:0]             rsp_to_y_ff, rsp_to_y_in;
   logic [3:0]             rsp_walls_ff, rsp_walls_in;
   logic                   rsp_more_ff, rsp_more_in;

   // Wall memory: two read ports, one write port
   logic [3:0]             wall_mem [CAP];
   logic [3:0]             wall_rd_a_ff, wall_rd_b_ff;
   logic [AW-1:0]          wall_raddr_a, wall_raddr_b;
   logic                   wall_re;
   logic                   wall_we;
   logic [AW-1:0]          wall_waddr;
   logic [3:0]             wall_wdata;

   // Stack memory: one read port, one write port
   logic [SW-1:0]          stk_mem [CAP];
   logic [SW-1:0]          stk_rd_ff;
   logic [DW-1:0]          stk_below;
   logic [AW-1:0]          stk_raddr;
   logic                   stk_we;
   logic [AW-1:0]          stk_waddr;
   logic [SW-1:0]          stk_wdata;

   // Combinational helpers
   logic                   req_fire;
   logic [13:0]            cell_count;
   logic                   complete;
   logic                   xin, yin;
   logic [3:0]             inb;
   logic [CW-1:0]          nbx [4];
   logic [RW-1:0]          nby [4];
   logic [AW-1:0]          nb_addr [4];
   logic [AW-1:0]          self_addr;
   logic [AW-1:0]          query_addr;
   logic                   query_ok;
   logic [3:0]             cand;
   logic [2:0]             cand_n;
   logic [1:0]             pick_rank;
   logic [1:0]             pick_dir;
   logic [2:0]             seen;
   logic                   found;
   logic                   rsp_load;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [RW-1:0] y);
      return AW'(y) * AW'(MAX_COLS) + AW'(x);
   endfunction

   function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v,
                                                  input int hi);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (int'(v) > hi) begin
         r = CFG_W'(hi);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Completion test on the current geometry
   assign cell_count = 14'(columns_ff) * 14'(rows_ff);
   assign complete   = (14'(carved_ff) + 14'd1) >= cell_count;

   // Neighbour coordinates and bounds, in search order
   assign xin = XW'(top_x_ff) < XW'(columns_ff);
   assign yin = XW'(top_y_ff) < XW'(rows_ff);
   assign inb[0] = (top_x_ff != '0) && (XW'(top_x_ff) <= XW'(columns_ff)) && yin;
   assign inb[1] = (top_y_ff != '0) && (XW'(top_y_ff) <= XW'(rows_ff)) && xin;
   assign inb[2] = ((XW'(top_y_ff) + XW'(1)) < XW'(rows_ff)) && xin;
   assign inb[3] = ((XW'(top_x_ff) + XW'(1)) < XW'(columns_ff)) && yin;

   assign nbx[0] = top_x_ff - CW'(1);
   assign nbx[1] = top_x_ff;
   assign nbx[2] = top_x_ff;
   assign nbx[3] = top_x_ff + CW'(1);
   assign nby[0] = top_y_ff;
   assign nby[1] = top_y_ff - RW'(1);
   assign nby[2] = top_y_ff + RW'(1);
   assign nby[3] = top_y_ff;

   assign self_addr = cell_addr(top_x_ff, top_y_ff);

   // Out-of-bounds neighbours read the own cell; the data is ignored
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         nb_addr[k] = inb[k] ? cell_addr(nbx[k], nby[k]) : self_addr;
      end
   end

   assign query_ok   = (int'(req_query_x) < MAX_COLS) && (int'(req_query_y) < MAX_ROWS);
   assign query_addr = query_ok ? cell_addr(CW'(req_query_x), RW'(req_query_y)) : '0;

   // Candidate choice: random value mod candidate count, then rank among set bits
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cand[k] = inb[k] && (nb_ff[k] == 4'b0000);
      end
      cand_n = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
      case (cand_n)
         3'd2:    pick_rank = {1'b0, rnd_ff[0]};
         3'd3:    pick_rank = mod3_u8(rnd_ff);
         3'd4:    pick_rank = rnd_ff[1:0];
         default: pick_rank = 2'd0;
      endcase
      seen     = '0;
      found    = 1'b0;
      pick_dir = DIR_MX;
      for (int k = 0; k < 4; k++) begin
         if (cand[k] && !found) begin
            if (seen[1:0] == pick_rank) begin
               pick_dir = 2'(k);
               found    = 1'b1;
            end
            seen = seen + 3'd1;
         end
      end
   end

   // Wall memory read addresses
   always_comb begin
      wall_raddr_a = self_addr;
      wall_raddr_b = self_addr;
      wall_re      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            wall_raddr_a = (req_action == ACT_READ) ? query_addr : nb_addr[0];
            wall_raddr_b = nb_addr[1];
            wall_re      = req_fire;
         end
         S_NB: begin
            wall_raddr_a = nb_addr[2];
            wall_raddr_b = nb_addr[3];
            wall_re      = 1'b1;
         end
         S_SELF: begin
            wall_re = 1'b1;
         end
         default: begin
            wall_re = 1'b0;
         end
      endcase
   end

   // Wall memory writes: sweep, new cell, then own cell
   always_comb begin
      wall_we    = 1'b0;
      wall_waddr = self_addr;
      wall_wdata = 4'b0000;
      case (state_ff)
         S_CLEAR: begin
            wall_we    = 1'b1;
            wall_waddr = clr_addr_ff;
         end
         S_PICK: begin
            wall_we    = (cand != 4'b0000);
            wall_waddr = nb_addr[pick_dir];
            wall_wdata = wall_to(pick_dir);
         end
         S_WRA: begin
            wall_we    = 1'b1;
            wall_wdata = self_ff | wall_from(dir_ff);
         end
         default: begin
            wall_we = 1'b0;
         end
      endcase
   end

   // Stack: entry below the top is read ahead for a pop
   assign stk_below = depth_ff - DW'(2);
   assign stk_raddr = stk_below[AW-1:0];

   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = '0;
      stk_wdata = {top_y_ff, top_x_ff};
      case (state_ff)
         S_CLEAR: begin
            stk_we = 1'b1;
         end
         S_WRA: begin
            stk_we    = depth_ff < DW'(CAP);
            stk_waddr = depth_ff[AW-1:0];
            stk_wdata = {tgt_y_ff, tgt_x_ff};
         end
         default: begin
            stk_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wall_we) begin
         wall_mem[wall_waddr] <= wall_wdata;
      end
      if (wall_re) begin
         wall_rd_a_ff <= wall_mem[wall_raddr_a];
         wall_rd_b_ff <= wall_mem[wall_raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      columns_in   = columns_ff;
      rows_in      = rows_ff;
      depth_in     = depth_ff;
      carved_in    = carved_ff;
      top_x_in     = top_x_ff;
      top_y_in     = top_y_ff;
      clr_addr_in  = clr_addr_ff;
      clr_reply_in = clr_reply_ff;
      status_in    = status_ff;
      from_x_in    = from_x_ff;
      from_y_in    = from_y_ff;
      tgt_x_in     = tgt_x_ff;
      tgt_y_in     = tgt_y_ff;
      rnd_in       = rnd_ff;
      qok_in       = qok_ff;
      dir_in       = dir_ff;
      self_in      = self_ff;
      for (int k = 0; k < 4; k++) begin
         nb_in[k] = nb_ff[k];
      end

      // Register writes
      if (csr_we) begin
         if (csr_index == REG_COLUMNS) begin
            columns_in = clamp_reg(csr_wdata, MAX_COLS);
         end else begin
            rows_in = clamp_reg(csr_wdata, MAX_ROWS);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rnd_in    = req_random_value;
               qok_in    = query_ok;
               tgt_x_in  = '0;
               tgt_y_in  = '0;
               from_x_in = (depth_ff != '0) ? 6'(top_x_ff) : 6'd0;
               from_y_in = (depth_ff != '0) ? 6'(top_y_ff) : 6'd0;
               case (req_action)
                  ACT_RESTART: begin
                     top_x_in     = CW'(columns_ff >> 1);
                     top_y_in     = RW'(rows_ff >> 1);
                     from_x_in    = 6'(columns_ff >> 1);
                     from_y_in    = 6'(rows_ff >> 1);
                     depth_in     = DW'(1);
                     carved_in    = '0;
                     clr_addr_in  = '0;
                     clr_reply_in = 1'b1;
                     status_in    = ST_RESTART;
                     state_in     = S_CLEAR;
                  end
                  ACT_READ: begin
                     status_in = ST_READ;
                     state_in  = S_DONE;
                  end
                  ACT_STEP: begin
                     if (complete || depth_ff == '0) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_NB;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(CAP - 1)) begin
               clr_reply_in = 1'b0;
               state_in     = clr_reply_ff ? S_DONE : S_IDLE;
            end
         end
         S_NB: begin
            nb_in[0] = wall_rd_a_ff;
            nb_in[1] = wall_rd_b_ff;
            state_in = S_SELF;
         end
         S_SELF: begin
            nb_in[2] = wall_rd_a_ff;
            nb_in[3] = wall_rd_b_ff;
            state_in = S_PICK;
         end
         S_PICK: begin
            self_in = wall_rd_a_ff;
            if (cand == 4'b0000) begin
               depth_in  = depth_ff - DW'(1);
               status_in = ST_BACK;
               state_in  = S_POP;
            end else begin
               dir_in    = pick_dir;
               tgt_x_in  = nbx[pick_dir];
               tgt_y_in  = nby[pick_dir];
               status_in = ST_CARVED;
               state_in  = S_WRA;
            end
         end
         S_WRA: begin
            if (depth_ff < DW'(CAP)) begin
               depth_in = depth_ff + DW'(1);
               top_x_in = tgt_x_ff;
               top_y_in = tgt_y_ff;
            end
            if (carved_ff != CARVED_MAX) begin
               carved_in = carved_ff + CARVED_W'(1);
            end
            state_in = S_DONE;
         end
         S_POP: begin
            if (depth_ff != '0) begin
               top_x_in = stk_rd_ff[CW-1:0];
               top_y_in = stk_rd_ff[SW-1:CW];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register load; more_to_do uses the settled state
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_from_x_in = rsp_from_x_ff;
      rsp_from_y_in = rsp_from_y_ff;
      rsp_to_x_in   = rsp_to_x_ff;
      rsp_to_y_in   = rsp_to_y_ff;
      rsp_walls_in  = rsp_walls_ff;
      rsp_more_in   = rsp_more_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_from_x_in = from_x_ff;
         rsp_from_y_in = from_y_ff;
         rsp_to_x_in   = 6'(tgt_x_ff);
         rsp_to_y_in   = 6'(tgt_y_ff);
         rsp_walls_in  = (status_ff == ST_READ && qok_ff) ? wall_rd_a_ff : 4'b0000;
         rsp_more_in   = !complete && (depth_ff != '0);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         columns_ff   <= CFG_W'(COL_RST);
         rows_ff      <= CFG_W'(ROW_RST);
         depth_ff     <= DW'(1);
         carved_ff    <= '0;
         top_x_ff     <= CW'(COL_RST / 2);
         top_y_ff     <= RW'(ROW_RST / 2);
         clr_addr_ff  <= '0;
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         depth_ff     <= depth_in;
         carved_ff    <= carved_in;
         top_x_ff     <= top_x_in;
         top_y_ff     <= top_y_in;
         clr_addr_ff  <= clr_addr_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      from_x_ff     <= from_x_in;
      from_y_ff     <= from_y_in;
      tgt_x_ff      <= tgt_x_in;
      tgt_y_ff      <= tgt_y_in;
      rnd_ff        <= rnd_in;
      qok_ff        <= qok_in;
      dir_ff        <= dir_in;
      self_ff       <= self_in;
      for (int k = 0; k < 4; k++) begin
         nb_ff[k] <= nb_in[k];
      end
      rsp_status_ff <= rsp_status_in;
      rsp_from_x_ff <= rsp_from_x_in;
      rsp_from_y_ff <= rsp_from_y_in;
      rsp_to_x_ff   <= rsp_to_x_in;
      rsp_to_y_ff   <= rsp_to_y_in;
      rsp_walls_ff  <= rsp_walls_in;
      rsp_more_ff   <= rsp_more_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_from_x     = rsp_from_x_ff;
   assign rsp_from_y     = rsp_from_y_ff;
   assign rsp_to_x       = rsp_to_x_ff;
   assign rsp_to_y       = rsp_to_y_ff;
   assign rsp_walls_open = rsp_walls_ff;
   assign rsp_more_to_do = rsp_more_ff;

endmodule

@@ rtl/mcd_checker.sv @@
`include "maze_carver_dfs_top_defines.svh"

module mcd_checker
   import mcd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [5:0] rsp_from_x,
   input logic [5:0] rsp_from_y,
   input logic [5:0] rsp_to_x,
   input logic [5:0] rsp_to_y,
   input logic [3:0] rsp_walls_open,
   input logic       rsp_more_to_do
);

   // A stalled result holds
   `MCD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_from_x) && $stable(rsp_from_y) && $stable(rsp_to_x) && $stable(rsp_to_y) && $stable(rsp_walls_open) && $stable(rsp_more_to_do), "result changed while stalled")

   // Only a carve names a target cell
   `MCD_ASSERT_NOW(a_to_zero, rsp_valid && rsp_status != ST_CARVED, rsp_to_x == 6'd0 && rsp_to_y == 6'd0, "target set on a non-carve result")

   // Only a read carries wall bits
   `MCD_ASSERT_NOW(a_walls_zero, rsp_valid && rsp_status != ST_READ, rsp_walls_open == 4'b0000, "walls set on a non-read result")

   // A finished step leaves nothing to do
   `MCD_ASSERT_NOW(a_full_idle, rsp_valid && rsp_status == ST_FULL, !rsp_more_to_do, "more_to_do set after a finished step")

endmodule

bind maze_carver_dfs_top mcd_checker u_mcd_checker (.*);

@@ bench/maze_carve_checker.sv @@
module maze_carve_checker
   import mcd_pkg::*;
#(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic [7:0]           req_random_value,
   input  logic [5:0]           req_query_x,
   input  logic [5:0]           req_query_y,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [2:0]           rsp_status,
   input  logic [5:0]           rsp_from_x,
   input  logic [5:0]           rsp_from_y,
   input  logic [5:0]           rsp_to_x,
   input  logic [5:0]           rsp_to_y,
   input  logic [3:0]           rsp_walls_open,
   input  logic                 rsp_more_to_do,
   output int                   errors,
   output int                   outstanding,
   output int                   checked,
   output int                   carves,
   output int                   backtracks
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = MAX_COLS * MAX_ROWS;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] from_x;
      logic [5:0] from_y;
      logic [5:0] to_x;
      logic [5:0] to_y;
      logic [3:0] walls_open;
      logic       more_to_do;
   } maze_result_t;

   // Own copy of the carver state
   logic [3:0] wall_map [0:MAX_ROWS-1][0:MAX_COLS-1];
   logic [5:0] trail_x  [0:CAPACITY-1];
   logic [5:0] trail_y  [0:CAPACITY-1];
   int         depth;
   int         carved;
   int         cols;
   int         rows;

   maze_result_t pending_outcomes [$];

   function automatic int clamp_extent(input logic [6:0] v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic bit maze_done();
      return carved + 1 >= cols * rows;
   endfunction

   function automatic void open_wall(input int x, input int y, input logic [3:0] bits);
      wall_map[y][x] = wall_map[y][x] | bits;
   endfunction

   // Wipe every wall and start again from the centre of the current grid
   function automatic void restart_maze();
      for (int y = 0; y < MAX_ROWS; y++) begin
         for (int x = 0; x < MAX_COLS; x++) begin
            wall_map[y][x] = 4'b0000;
         end
      end
      trail_x[0] = 6'(cols / 2);
      trail_y[0] = 6'(rows / 2);
      depth      = 1;
      carved     = 0;
   endfunction

   // Outcome of one request, updating the local state as the block should
   function automatic maze_result_t carve_outcome(input logic [1:0] act,
                                                  input logic [7:0] rnd,
                                                  input logic [5:0] qx,
                                                  input logic [5:0] qy);
      maze_result_t res;
      int fx;
      int fy;
      int nx;
      int ny;
      int tx;
      int ty;
      int n;
      int pick;
      int cand_x [4];
      int cand_y [4];
      res = '0;
      fx  = 0;
      fy  = 0;
      if (act == ACT_RESTART) restart_maze();
      if (depth > 0) begin
         fx = int'(trail_x[depth-1]);
         fy = int'(trail_y[depth-1]);
      end
      case (act)
         ACT_RESTART: begin
            res.status = ST_RESTART;
         end
         ACT_READ: begin
            res.status = ST_READ;
            if (qx < MAX_COLS && qy < MAX_ROWS) res.walls_open = wall_map[qy][qx];
         end
         default: begin
            if (maze_done() || depth == 0) begin
               res.status = ST_FULL;
            end else begin
               // gather fresh neighbours in search order
               n = 0;
               for (int k = 0; k < 4; k++) begin
                  case (2'(k))
                     DIR_MX:  begin nx = fx - 1; ny = fy;     end
                     DIR_MY:  begin nx = fx;     ny = fy - 1; end
                     DIR_PY:  begin nx = fx;     ny = fy + 1; end
                     default: begin nx = fx + 1; ny = fy;     end
                  endcase
                  if (nx >= 0 && ny >= 0 && nx < cols && ny < rows) begin
                     if (wall_map[ny][nx] == 4'b0000) begin
                        cand_x[n] = nx;
                        cand_y[n] = ny;
                        n++;
                     end
                  end
               end
               if (n == 0) begin
                  depth--;
                  res.status = ST_BACK;
               end else begin
                  pick = int'(rnd) % n;
                  tx   = cand_x[pick];
                  ty   = cand_y[pick];
                  if (ty < fy) begin open_wall(fx, fy, W_MY); open_wall(tx, ty, W_PY); end
                  if (ty > fy) begin open_wall(fx, fy, W_PY); open_wall(tx, ty, W_MY); end
                  if (tx > fx) begin open_wall(fx, fy, W_PX); open_wall(tx, ty, W_MX); end
                  if (tx < fx) begin open_wall(fx, fy, W_MX); open_wall(tx, ty, W_PX); end
                  if (depth < CAPACITY) begin
                     trail_x[depth] = 6'(tx);
                     trail_y[depth] = 6'(ty);
                     depth++;
                  end
                  if (carved < CARVED_MAX) carved++;
                  res.status = ST_CARVED;
                  res.to_x   = 6'(tx);
                  res.to_y   = 6'(ty);
               end
            end
         end
      endcase
      res.from_x     = 6'(fx);
      res.from_y     = 6'(fy);
      res.more_to_do = !maze_done() && depth > 0;
      return res;
   endfunction

   // Results are checked before new requests so a same-edge pair cannot cross
   always @(posedge clock) begin : track
      maze_result_t want;
      int bad;
      bad = 0;
      if (reset) begin
         cols = (MAX_COLS < 64) ? MAX_COLS : 64;
         rows = (MAX_ROWS < 64) ? MAX_ROWS : 64;
         restart_maze();
         pending_outcomes.delete();
         errors      <= 0;
         outstanding <= 0;
         checked     <= 0;
         carves      <= 0;
         backtracks  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $error("result transfer with nothing expected: status %0d", rsp_status);
               bad++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  bad++;
               end
               if (rsp_from_x !== want.from_x) begin
                  $error("from_x: expected %0d, got %0d", want.from_x, rsp_from_x);
                  bad++;
               end
               if (rsp_from_y !== want.from_y) begin
                  $error("from_y: expected %0d, got %0d", want.from_y, rsp_from_y);
                  bad++;
               end
               if (rsp_to_x !== want.to_x) begin
                  $error("to_x: expected %0d, got %0d", want.to_x, rsp_to_x);
                  bad++;
               end
               if (rsp_to_y !== want.to_y) begin
                  $error("to_y: expected %0d, got %0d", want.to_y, rsp_to_y);
                  bad++;
               end
               if (rsp_walls_open !== want.walls_open) begin
                  $error("walls_open: expected %0h, got %0h", want.walls_open, rsp_walls_open);
                  bad++;
               end
               if (rsp_more_to_do !== want.more_to_do) begin
                  $error("more_to_do: expected %0d, got %0d", want.more_to_do, rsp_more_to_do);
                  bad++;
               end
               checked <= checked + 1;
               if (want.status == ST_CARVED) carves <= carves + 1;
               if (want.status == ST_BACK) backtracks <= backtracks + 1;
            end
         end
         // geometry registers, clamped into range
         if (csr_we) begin
            if (csr_index == REG_COLUMNS) cols = clamp_extent(csr_wdata, MAX_COLS);
            else if (csr_index == REG_ROWS) rows = clamp_extent(csr_wdata, MAX_ROWS);
         end
         if (req_valid && req_ready) begin
            case (req_action)
               ACT_RESTART, ACT_STEP, ACT_READ:
                  pending_outcomes.push_back(carve_outcome(req_action, req_random_value,
                                                           req_query_x, req_query_y));
               default: ; // dropped by the block, nothing comes back
            endcase
         end
         errors      <= errors + bad;
         outstanding <= pending_outcomes.size();
      end
   end

endmodule

@@ bench/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mcd_pkg::*;

   localparam int          ITEM_TARGET  = 1200;
   localparam int          LIMIT_CYCLES = 2_000_000;
   localparam int          SETTLE       = 16;
   localparam int          HOLD_CYCLES  = 300;
   localparam logic [1:0]  ACT_IGNORED  = 2'd3;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [CFG_W-1:0]     csr_wdata        = '0;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_action       = '0;
   logic [7:0]           req_random_value = '0;
   logic [5:0]           req_query_x      = '0;
   logic [5:0]           req_query_y      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [2:0]           rsp_status;
   logic [5:0]           rsp_from_x;
   logic [5:0]           rsp_from_y;
   logic [5:0]           rsp_to_x;
   logic [5:0]           rsp_to_y;
   logic [3:0]           rsp_walls_open;
   logic                 rsp_more_to_do;

   int errors;
   int outstanding;
   int checked;
   int carves;
   int backtracks;

   int sent       = 0;
   int restarts   = 0;
   int reg_writes = 0;
   int cycles     = 0;
   int squeeze    = 0;
   bit calm       = 1'b0;

   maze_carver_dfs_top uut (.*);

   maze_carve_checker watch (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one request and hold it until the transfer
   task automatic offer(input logic [1:0] act, input logic [7:0] rnd,
                        input logic [5:0] qx, input logic [5:0] qy);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_random_value <= rnd;
      req_query_x      <= qx;
      req_query_y      <= qy;
      do @(posedge clock); while (!req_ready);
      if (act != ACT_IGNORED) sent++;
      if (act == ACT_RESTART) restarts++;
   endtask

   // Wait until every result is back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   // Mostly small grids, now and then the extremes or an out-of-range value
   function automatic logic [CFG_W-1:0] pick_extent();
      case ($urandom_range(0, 19))
         0:       return 7'd64;
         1:       return 7'd1;
         2:       return 7'd0;
         3:       return 7'($urandom_range(65, 127));
         default: return 7'($urandom_range(1, 7));
      endcase
   endfunction

   function automatic logic [5:0] pick_coord();
      if ($urandom_range(0, 4) == 0) return 6'($urandom_range(0, 63));
      return 6'($urandom_range(0, 7));
   endfunction

   // Receiver: random stalls, plus a long hold-off when asked for
   initial begin : result_side
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (squeeze > 0) begin
            rsp_ready <= 1'b0;
            repeat (squeeze) @(posedge clock);
            squeeze = 0;
         end
         stall = calm ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : request_side
      int target;
      int len;
      int roll;
      int phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default 64 by 64 grid straight after reset
      offer(ACT_STEP, 8'hFF, 6'd0, 6'd0);
      offer(ACT_STEP, 8'h00, 6'h3F, 6'h3F);
      offer(ACT_READ, 8'h00, 6'd32, 6'd32);
      offer(ACT_READ, 8'hFF, 6'h3F, 6'h3F);
      offer(ACT_IGNORED, 8'hFF, 6'h3F, 6'h3F);

      // single cell: finished the moment it starts
      settle();
      set_reg(REG_COLUMNS, 7'd1);
      set_reg(REG_ROWS, 7'd1);
      offer(ACT_RESTART, 8'h00, 6'd0, 6'd0);
      offer(ACT_STEP, 8'h55, 6'd0, 6'd0);
      offer(ACT_READ, 8'hAA, 6'd0, 6'd0);

      // out-of-range writes clamp to one column by the full height
      settle();
      set_reg(REG_COLUMNS, 7'd0);
      set_reg(REG_ROWS, 7'h7F);
      offer(ACT_RESTART, 8'h00, 6'd0, 6'd0);
      offer(ACT_STEP, 8'h01, 6'd0, 6'd0);

      // shrink the grid under a live walk: it backtracks off the stack, then finds it empty
      settle();
      set_reg(REG_COLUMNS, 7'd8);
      set_reg(REG_ROWS, 7'd8);
      offer(ACT_RESTART, 8'h00, 6'd0, 6'd0);
      offer(ACT_STEP, 8'h02, 6'd0, 6'd0);
      offer(ACT_STEP, 8'h03, 6'd0, 6'd0);
      settle();
      set_reg(REG_COLUMNS, 7'd2);
      set_reg(REG_ROWS, 7'd2);
      repeat (4) offer(ACT_STEP, 8'h07, 6'd0, 6'd0);

      // back-to-back steps while the result side holds off
      settle();
      set_reg(REG_COLUMNS, 7'd6);
      set_reg(REG_ROWS, 7'd6);
      offer(ACT_RESTART, 8'h00, 6'd0, 6'd0);
      squeeze = HOLD_CYCLES;
      calm    = 1'b1;
      repeat (8) offer(ACT_STEP, 8'($urandom), pick_coord(), pick_coord());
      calm    = 1'b0;

      // random phases: new geometry, restart, then mostly steps
      target = sent + ITEM_TARGET;
      phase  = 0;
      while (sent < target) begin
         settle();
         if ($urandom_range(0, 3) != 0) set_reg(REG_COLUMNS, pick_extent());
         if ($urandom_range(0, 3) != 0) set_reg(REG_ROWS, pick_extent());
         calm = ($urandom_range(0, 4) == 0);
         if (phase == 3 || phase == 14) squeeze = HOLD_CYCLES;
         phase++;
         offer(ACT_RESTART, 8'($urandom), pick_coord(), pick_coord());
         len = $urandom_range(15, 50);
         for (int i = 0; i < len && sent < target; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 66) begin
               offer(ACT_STEP, 8'($urandom), pick_coord(), pick_coord());
            end else if (roll < 86) begin
               offer(ACT_READ, 8'($urandom), pick_coord(), pick_coord());
            end else if (roll < 94) begin
               offer(ACT_IGNORED, 8'($urandom), pick_coord(), pick_coord());
            end else if (roll < 96) begin
               offer(ACT_RESTART, 8'($urandom), pick_coord(), pick_coord());
            end else begin
               // geometry change without a restart
               settle();
               set_reg(CSR_IDX_W'($urandom_range(0, 1)), pick_extent());
            end
         end
      end

      settle();
      $display("Run sent %0d requests with %0d restarts and %0d geometry register writes;",
               sent, restarts, reg_writes);
      $display("%0d results checked, among them %0d carves and %0d backtracks.",
               checked, carves, backtracks);
      if (errors == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mcd_pkg.sv
rtl/maze_carver_dfs_top.sv
rtl/mcd_checker.sv
bench/maze_carve_checker.sv
bench/tb.sv
